// ===== hw/rtl/sphere_box_local_contact_defines.svh =====
// Assertion macros shared by the sphere-box contact RTL.
`ifndef SPHERE_BOX_LOCAL_CONTACT_DEFINES_SVH
`define SPHERE_BOX_LOCAL_CONTACT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sbc_pkg.sv =====
// Package with widths, the side-band type and the face-depth saturation helper of the sphere-box contact block.
package sbc_pkg;

	localparam int CW  = 32;
	localparam int HW  = CW - 1;
	localparam int SQW = 2 * HW;

	typedef struct packed {
		logic                   dec;
		logic                   hit;
		logic                   in_box;
		logic [2:0][CW-1:0]     f;
		logic [2:0]             neg;
		logic [HW-1:0]          rad;
		logic [2:0][HW-1:0]     m;
		logic                   close;
		logic                   dz;
	} side_t;

	function automatic logic [CW-1:0] sat_face(input logic [CW:0] depth, input logic neg);
		logic [CW:0]   lim;
		logic [CW-1:0] res;
		lim = (CW+1)'(1) << (CW-1);
		if (!neg) begin
			res = (depth >= lim) ? (CW'(lim) - CW'(1)) : depth[CW-1:0];
		end else begin
			res = (depth >= lim) ? CW'(lim) : (CW'(0) - depth[CW-1:0]);
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/sphere_box_local_contact.sv =====
// Top level of the sphere against box contact pipeline.
// One word enters per cycle while the output word is not stalled; the 31-stage root
// and 31-stage divide pipelines make up most of the pipeline depth.
// The whole pipeline advances together and holds while the output word waits.
// Reset clears all valid bits asynchronously; data registers are not reset.
`include "sphere_box_local_contact_defines.svh"

module sphere_box_local_contact (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [sbc_pkg::CW-1:0] center_x,
	input  logic signed [sbc_pkg::CW-1:0] center_y,
	input  logic signed [sbc_pkg::CW-1:0] center_z,
	input  logic [sbc_pkg::HW-1:0]        sphere_radius,
	input  logic [sbc_pkg::HW-1:0]        box_half_x,
	input  logic [sbc_pkg::HW-1:0]        box_half_y,
	input  logic [sbc_pkg::HW-1:0]        box_half_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic                          inside_res,
	output logic signed [sbc_pkg::CW-1:0] pen_x,
	output logic signed [sbc_pkg::CW-1:0] pen_y,
	output logic signed [sbc_pkg::CW-1:0] pen_z
);

	localparam int CW  = sbc_pkg::CW;
	localparam int HW  = sbc_pkg::HW;
	localparam int SQW = sbc_pkg::SQW;

	logic en;

	logic [2:0][CW-1:0] p, a, h, md;
	logic [2:0][CW:0]   hr, depth;
	logic [2:0]         lt, gt, face_hit;
	logic               edge_reg;
	sbc_pkg::side_t     side0;

	logic                     v_s1, v_s2, v_s3, v_s4, v_out_q;
	logic [2:0][CW-1:0]       md_s1;
	sbc_pkg::side_t           side_s1, side_s2, side_s3, side_s4;
	logic [2:0][2*CW-1:0]     sq_s2;
	logic [SQW-1:0]           rr_s2;
	logic [2*CW-1:0]          ss;
	logic [SQW-1:0]           rad_s3;
	sbc_pkg::side_t           close_side, root_side;

	logic                     sq_v;
	logic [HW-1:0]            sq_root;
	sbc_pkg::side_t           sq_side;
	logic [HW-1:0]            rm;
	logic [2:0][SQW-1:0]      prod_s4;
	logic [HW-1:0]            dist_s4;

	logic                     dv_v;
	logic [2:0][HW-1:0]       quo;
	sbc_pkg::side_t           dv_side;

	logic                     hit_q, inside_q;
	logic [2:0][CW-1:0]       pen_q;
	logic [2:0][CW-1:0]       pen_n;
	logic                     hit_n;

	assign en       = !v_out_q || out_ready;
	assign in_ready = en;

	always_comb begin
		p[0] = center_x;
		p[1] = center_y;
		p[2] = center_z;
		h[0] = {1'b0, box_half_x};
		h[1] = {1'b0, box_half_y};
		h[2] = {1'b0, box_half_z};
		for (int k = 0; k < 3; k++) begin
			a[k]     = p[k][CW-1] ? (CW'(0) - p[k]) : p[k];
			lt[k]    = a[k] < h[k];
			gt[k]    = a[k] > h[k];
			hr[k]    = {1'b0, h[k]} + (CW+1)'(sphere_radius);
			depth[k] = hr[k] - {1'b0, a[k]};
		end
		for (int k = 0; k < 3; k++) begin
			face_hit[k] = (&(lt | (3'b001 << k))) && ({1'b0, a[k]} < hr[k]);
		end
		edge_reg = $countones(gt) == 2;
		side0        = '0;
		side0.rad    = sphere_radius;
		side0.in_box = &lt;
		side0.hit    = &lt;
		side0.dec    = &lt;
		for (int k = 0; k < 3; k++) begin
			if (!side0.dec && face_hit[k]) begin
				side0.dec  = 1'b1;
				side0.hit  = 1'b1;
				side0.f[k] = sbc_pkg::sat_face(depth[k], p[k][CW-1]);
			end
		end
		for (int k = 0; k < 3; k++) begin
			md[k]         = gt[k] ? (a[k] - h[k]) : (edge_reg ? CW'(0) : (h[k] - a[k]));
			side0.neg[k]  = gt[k] ? p[k][CW-1] : !p[k][CW-1];
			side0.m[k]    = md[k][HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_out_q <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= sq_v;
			v_out_q <= dv_v;
		end
	end

	always_comb begin
		close_side       = side_s2;
		close_side.close = ss < {(2*CW-SQW)'(0), rr_s2};
		root_side        = sq_side;
		root_side.dz     = sq_root == '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			md_s1   <= md;
			side_s1 <= side0;
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= {CW'(0), md_s1[k]} * {CW'(0), md_s1[k]};
			end
			rr_s2   <= {HW'(0), side_s1.rad} * {HW'(0), side_s1.rad};
			side_s2 <= side_s1;
			rad_s3  <= ss[SQW-1:0];
			side_s3 <= close_side;
			for (int k = 0; k < 3; k++) begin
				prod_s4[k] <= {HW'(0), sq_side.m[k]} * {HW'(0), rm};
			end
			dist_s4 <= sq_root;
			side_s4 <= root_side;
		end
	end

	assign ss = sq_s2[0] + sq_s2[1] + sq_s2[2];
	assign rm = sq_side.rad - sq_root;

	sbc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s3),
		.radicand (rad_s3),
		.in_side  (side_s3),
		.out_v    (sq_v),
		.root     (sq_root),
		.out_side (sq_side)
	);

	sbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s4),
		.num      (prod_s4),
		.den      (dist_s4),
		.in_side  (side_s4),
		.out_v    (dv_v),
		.quo      (quo),
		.out_side (dv_side)
	);

	always_comb begin
		hit_n = dv_side.dec ? dv_side.hit : dv_side.close;
		for (int k = 0; k < 3; k++) begin
			if (dv_side.dec) begin
				pen_n[k] = dv_side.f[k];
			end else if (dv_side.close && !dv_side.dz) begin
				pen_n[k] = dv_side.neg[k] ? (CW'(0) - CW'(quo[k])) : CW'(quo[k]);
			end else begin
				pen_n[k] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q    <= hit_n;
			inside_q <= dv_side.in_box;
			pen_q    <= pen_n;
		end
	end

	assign out_valid  = v_out_q;
	assign hit        = hit_q;
	assign inside_res = inside_q;
	assign pen_x      = pen_q[0];
	assign pen_y      = pen_q[1];
	assign pen_z      = pen_q[2];

	`SBC_ASSERT_NOW(a_inside_hit, out_valid && inside_res, hit, "inside word without hit")
	`SBC_ASSERT_NOW(a_miss_zero, out_valid && !hit,
		pen_x == 0 && pen_y == 0 && pen_z == 0, "miss word with nonzero vector")
	`SBC_ASSERT_NOW(a_inside_zero, out_valid && inside_res,
		pen_x == 0 && pen_y == 0 && pen_z == 0, "inside word with nonzero vector")
	`SBC_ASSERT_NOW(a_stall, out_valid && !out_ready, !in_ready, "input taken during stall")
	`SBC_ASSERT_NOW(a_s1_dec, v_s1 && side_s1.in_box, side_s1.dec && side_s1.hit,
		"inside case not decided early")

endmodule

// ===== hw/rtl/sbc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module sbc_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_v,
	input  logic [sbc_pkg::SQW-1:0]  radicand,
	input  sbc_pkg::side_t           in_side,
	output logic                     out_v,
	output logic [sbc_pkg::HW-1:0]   root,
	output sbc_pkg::side_t           out_side
);

	logic                    v_sn    [sbc_pkg::HW+1];
	logic [sbc_pkg::SQW:0]   rem_sn  [sbc_pkg::HW+1];
	logic [sbc_pkg::HW-1:0]  root_sn [sbc_pkg::HW+1];
	sbc_pkg::side_t          side_sn [sbc_pkg::HW+1];

	assign v_sn[0]    = in_v;
	assign rem_sn[0]  = {1'b0, radicand};
	assign root_sn[0] = '0;
	assign side_sn[0] = in_side;

	for (genvar g = 0; g < sbc_pkg::HW; g++) begin : g_st
		localparam int B = sbc_pkg::HW - 1 - g;
		logic [sbc_pkg::SQW:0] trial;
		logic                  take;

		always_comb begin
			trial = ((sbc_pkg::SQW+1)'(root_sn[g]) << (B + 1))
				+ ((sbc_pkg::SQW+1)'(1) << (2 * B));
			take  = rem_sn[g] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[g+1] <= 1'b0;
			end else if (en) begin
				v_sn[g+1] <= v_sn[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[g+1]  <= take ? (rem_sn[g] - trial) : rem_sn[g];
				root_sn[g+1] <= take ? (root_sn[g] | (sbc_pkg::HW'(1) << B)) : root_sn[g];
				side_sn[g+1] <= side_sn[g];
			end
		end
	end

	assign out_v    = v_sn[sbc_pkg::HW];
	assign root     = root_sn[sbc_pkg::HW];
	assign out_side = side_sn[sbc_pkg::HW];

endmodule

// ===== hw/rtl/sbc_div.sv =====
// Pipelined restoring divider, three dividends over one shared divisor.
module sbc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_v,
	input  logic [2:0][sbc_pkg::SQW-1:0]    num,
	input  logic [sbc_pkg::HW-1:0]          den,
	input  sbc_pkg::side_t                  in_side,
	output logic                            out_v,
	output logic [2:0][sbc_pkg::HW-1:0]     quo,
	output sbc_pkg::side_t                  out_side
);

	logic                             v_sn    [sbc_pkg::HW+1];
	logic [2:0][sbc_pkg::SQW-1:0]     rem_sn  [sbc_pkg::HW+1];
	logic [2:0][sbc_pkg::HW-1:0]      quo_sn  [sbc_pkg::HW+1];
	logic [sbc_pkg::HW-1:0]           den_sn  [sbc_pkg::HW+1];
	sbc_pkg::side_t                   side_sn [sbc_pkg::HW+1];

	assign v_sn[0]    = in_v;
	assign rem_sn[0]  = num;
	assign quo_sn[0]  = '0;
	assign den_sn[0]  = den;
	assign side_sn[0] = in_side;

	for (genvar g = 0; g < sbc_pkg::HW; g++) begin : g_st
		localparam int B = sbc_pkg::HW - 1 - g;
		logic [sbc_pkg::SQW-1:0]          sub;
		logic [2:0][sbc_pkg::SQW-1:0]     rem_n;
		logic [2:0][sbc_pkg::HW-1:0]      quo_n;

		always_comb begin
			sub = sbc_pkg::SQW'(den_sn[g]) << B;
			for (int k = 0; k < 3; k++) begin
				if (rem_sn[g][k] >= sub) begin
					rem_n[k] = rem_sn[g][k] - sub;
					quo_n[k] = quo_sn[g][k] | (sbc_pkg::HW'(1) << B);
				end else begin
					rem_n[k] = rem_sn[g][k];
					quo_n[k] = quo_sn[g][k];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[g+1] <= 1'b0;
			end else if (en) begin
				v_sn[g+1] <= v_sn[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[g+1]  <= rem_n;
				quo_sn[g+1]  <= quo_n;
				den_sn[g+1]  <= den_sn[g];
				side_sn[g+1] <= side_sn[g];
			end
		end
	end

	assign out_v    = v_sn[sbc_pkg::HW];
	assign quo      = quo_sn[sbc_pkg::HW];
	assign out_side = side_sn[sbc_pkg::HW];

endmodule
